[sv/tkll_pkg.sv]
// ----------------------------------------------------------------------------
// tkll_pkg: shared types for the top-k longest lines unit
// Field widths, the sequencer state type and the table entry layout.
// ----------------------------------------------------------------------------
package tkll_pkg;

  localparam int unsigned LEN_W   = 12;
  localparam int unsigned LNO_W   = 24;
  localparam logic [LNO_W-1:0] LNO_MAX = {LNO_W{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RSCAN,
    ST_LOAD
  } tkll_state_e;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [LNO_W-1:0] lno;
  } tkll_entry_t;

endpackage

[sv/top_k_longest_lines_unit.sv]
// ----------------------------------------------------------------------------
// top_k_longest_lines_unit: keeps the longest lines of a text, ranked
// Numbers lines, keeps up to TOP_COUNT entries of distinct length and emits
// them in descending length order on the line marked final.
// ----------------------------------------------------------------------------
// Stall: after a plain line's transfer, in_stall_o stays high through the scan of
//   every slot through the registered read and through the update.
// Throughput: a new line is taken only once the scan and update of the last end.
// Readout: each ranked result takes a max-search scan of every slot plus a load,
//   plus any time the output stalls; it starts after the final update.
// Reset: rst_ni clears slot-used bits, fill count, line counter and sequencer.
module top_k_longest_lines_unit #(
  parameter int unsigned TOP_COUNT = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tkll_pkg::LEN_W-1:0] line_length_i,
  input  logic                       final_line_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tkll_pkg::LEN_W-1:0] entry_length_o,
  output logic [tkll_pkg::LNO_W-1:0] entry_line_number_o,
  output logic                       entry_valid_o,
  output logic                       last_result_o
);

  import tkll_pkg::*;

  // Index width addresses a slot; count width also holds TOP_COUNT itself.
  localparam int unsigned IW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int unsigned CW = $clog2(TOP_COUNT + 1);
  localparam logic [CW-1:0] CNT_END = CW'(TOP_COUNT);

  // Table memory: one length / line-number pair per slot, registered read.
  tkll_entry_t mem [TOP_COUNT];
  tkll_entry_t rd_q;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  tkll_entry_t mem_wdata;
  logic        rd_en;
  logic [IW-1:0] rd_addr;

  // Sequencer and control state.
  tkll_state_e state_q, state_d;
  logic [TOP_COUNT-1:0] used_q, used_d;
  logic [TOP_COUNT-1:0] taken_q, taken_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [LNO_W-1:0] line_cnt_q, line_cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] rank_q, rank_d;
  logic          pipe_vld_q, pipe_vld_d;
  logic [IW-1:0] pipe_idx_q, pipe_idx_d;

  // Current item.
  logic [LEN_W-1:0] len_q, len_d;
  logic [LNO_W-1:0] lno_q, lno_d;
  logic             final_q, final_d;

  // Scan results of the insertion pass.
  logic          dup_q, dup_d;
  logic          free_found_q, free_found_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic          min_found_q, min_found_d;
  logic [LEN_W-1:0] min_len_q, min_len_d;
  logic [IW-1:0] min_idx_q, min_idx_d;

  // Running best of the readout pass.
  logic          best_found_q, best_found_d;
  tkll_entry_t   best_q, best_d;
  logic [IW-1:0] best_idx_q, best_idx_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [LEN_W-1:0] out_len_q, out_len_d;
  logic [LNO_W-1:0] out_lno_q, out_lno_d;
  logic             out_ev_q, out_ev_d;
  logic             out_last_q, out_last_d;

  logic is_last;

  assign in_stall_o          = (state_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign entry_length_o      = out_len_q;
  assign entry_line_number_o = out_lno_q;
  assign entry_valid_o       = out_ev_q;
  assign last_result_o       = out_last_q;

  assign is_last = (rank_q == CW'(fill_q - CW'(1)));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    taken_d      = taken_q;
    fill_d       = fill_q;
    line_cnt_d   = line_cnt_q;
    idx_d        = idx_q;
    rank_d       = rank_q;
    pipe_vld_d   = 1'b0;
    pipe_idx_d   = pipe_idx_q;
    len_d        = len_q;
    lno_d        = lno_q;
    final_d      = final_q;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    min_found_d  = min_found_q;
    min_len_d    = min_len_q;
    min_idx_d    = min_idx_q;
    best_found_d = best_found_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_len_d    = out_len_q;
    out_lno_d    = out_lno_q;
    out_ev_d     = out_ev_q;
    out_last_d   = out_last_q;
    mem_we       = 1'b0;
    mem_waddr    = free_idx_q;
    mem_wdata    = '{len: len_q, lno: lno_q};
    rd_en        = 1'b0;
    rd_addr      = idx_q[IW-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // Number the line, saturating at the top of the range.
          lno_d        = (line_cnt_q == LNO_MAX) ? line_cnt_q : line_cnt_q + LNO_W'(1);
          line_cnt_d   = lno_d;
          len_d        = line_length_i;
          final_d      = final_line_i;
          idx_d        = '0;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          min_found_d  = 1'b0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one slot read a cycle; compare the slot read last cycle.
        if (idx_q != CNT_END) begin
          rd_en      = 1'b1;
          pipe_vld_d = 1'b1;
          pipe_idx_d = idx_q[IW-1:0];
          idx_d      = idx_q + CW'(1);
        end
        if (pipe_vld_q) begin
          if (!used_q[pipe_idx_q]) begin
            if (!free_found_q) begin
              free_found_d = 1'b1;
              free_idx_d   = pipe_idx_q;
            end
          end else begin
            if (rd_q.len == len_q) begin
              dup_d = 1'b1;
            end
            if (!min_found_q || (rd_q.len < min_len_q)) begin
              min_found_d = 1'b1;
              min_len_d   = rd_q.len;
              min_idx_d   = pipe_idx_q;
            end
          end
        end else if (idx_q == CNT_END) begin
          state_d = ST_UPDATE;
        end
      end

      ST_UPDATE: begin
        // Unless the length is already held, fill the first free slot, else replace the shortest if longer.
        if (!dup_q) begin
          if (free_found_q) begin
            mem_we             = 1'b1;
            mem_waddr          = free_idx_q;
            used_d[free_idx_q] = 1'b1;
            fill_d             = fill_q + CW'(1);
          end else if (min_found_q && (len_q > min_len_q)) begin
            mem_we    = 1'b1;
            mem_waddr = min_idx_q;
          end
        end
        if (final_q) begin
          idx_d        = '0;
          rank_d       = '0;
          best_found_d = 1'b0;
          taken_d      = '0;
          state_d      = ST_RSCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_RSCAN: begin
        // Find the longest slot not yet emitted.
        if (idx_q != CNT_END) begin
          rd_en      = 1'b1;
          pipe_vld_d = 1'b1;
          pipe_idx_d = idx_q[IW-1:0];
          idx_d      = idx_q + CW'(1);
        end
        if (pipe_vld_q) begin
          if (used_q[pipe_idx_q] && !taken_q[pipe_idx_q] &&
              (!best_found_q || (rd_q.len > best_q.len))) begin
            best_found_d = 1'b1;
            best_d       = rd_q;
            best_idx_d   = pipe_idx_q;
          end
        end else if (idx_q == CNT_END) begin
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        // Hold until the output register is free, then load one result.
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if (fill_q == '0 || !best_found_q) begin
            out_len_d  = '0;
            out_lno_d  = '0;
            out_ev_d   = 1'b0;
            out_last_d = 1'b1;
          end else begin
            out_len_d           = best_q.len;
            out_lno_d           = best_q.lno;
            out_ev_d            = 1'b1;
            out_last_d          = is_last;
            taken_d[best_idx_q] = 1'b1;
          end
          if (fill_q == '0 || !best_found_q || is_last) begin
            // Readout done: drop the table and restart numbering.
            used_d     = '0;
            fill_d     = '0;
            line_cnt_d = '0;
            state_d    = ST_IDLE;
          end else begin
            rank_d       = rank_q + CW'(1);
            idx_d        = '0;
            best_found_d = 1'b0;
            state_d      = ST_RSCAN;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      used_q       <= '0;
      taken_q      <= '0;
      fill_q       <= '0;
      line_cnt_q   <= '0;
      idx_q        <= '0;
      rank_q       <= '0;
      pipe_vld_q   <= 1'b0;
      final_q      <= 1'b0;
      dup_q        <= 1'b0;
      free_found_q <= 1'b0;
      min_found_q  <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      taken_q      <= taken_d;
      fill_q       <= fill_d;
      line_cnt_q   <= line_cnt_d;
      idx_q        <= idx_d;
      rank_q       <= rank_d;
      pipe_vld_q   <= pipe_vld_d;
      final_q      <= final_d;
      dup_q        <= dup_d;
      free_found_q <= free_found_d;
      min_found_q  <= min_found_d;
      best_found_q <= best_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    pipe_idx_q <= pipe_idx_d;
    len_q      <= len_d;
    lno_q      <= lno_d;
    free_idx_q <= free_idx_d;
    min_len_q  <= min_len_d;
    min_idx_q  <= min_idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_len_q  <= out_len_d;
    out_lno_q  <= out_lno_d;
    out_ev_q   <= out_ev_d;
    out_last_q <= out_last_d;
  end

endmodule
